// File: rtl/piecewise_linear_mapper_defines.svh
// Assertion helpers used by the mapper sequencer.
`ifndef PIECEWISE_LINEAR_MAPPER_DEFINES_SVH
`define PIECEWISE_LINEAR_MAPPER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PLM_ASSERT_NOW(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PLM_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// File: rtl/plm_pkg.sv
package plm_pkg;

    // Sample and curve point width (Q7.8).
    localparam int DATA_WIDTH   = 16;
    localparam int MAX_SEGMENTS = 8;
    localparam int NUM_PAIRS    = 5;
    localparam int NUM_POINTS   = 2 * NUM_PAIRS;
    localparam int PT_IDX_W     = $clog2(NUM_POINTS);
    localparam int SEG_W        = 4;
    localparam int REGION_W     = 2;
    localparam int MODE_W       = 2;

    // Fractional bits of the interpolation ratio.
    localparam int FRAC_BITS = 16;
    localparam int QUO_W     = DATA_WIDTH + FRAC_BITS;
    localparam int ACC_W     = QUO_W + DATA_WIDTH;
    localparam int ALU_W     = ACC_W + 2;
    localparam int CNT_W     = $clog2(QUO_W);

    // Saturation bounds of the result, at adder width.
    localparam logic signed [ALU_W-1:0] SAT_HI = ALU_W'((2 ** (DATA_WIDTH - 1)) - 1);
    localparam logic signed [ALU_W-1:0] SAT_LO = -SAT_HI - ALU_W'(1);

    // Configuration port.
    localparam int APB_DW = 64;
    localparam int ADDR_W = 6;
    localparam int REG_W  = 3;

    localparam logic [REG_W-1:0] REG_SEGMENT_COUNT = 3'd0;
    localparam logic [REG_W-1:0] REG_MODE          = 3'd1;
    localparam logic [REG_W-1:0] REG_PAIR_0        = 3'd2;
    localparam logic [REG_W-1:0] REG_PAIR_1        = 3'd3;
    localparam logic [REG_W-1:0] REG_PAIR_2        = 3'd4;
    localparam logic [REG_W-1:0] REG_PAIR_3        = 3'd5;
    localparam logic [REG_W-1:0] REG_PAIR_4        = 3'd6;

    // Mode bits.
    localparam int MODE_EXTRAP = 0;
    localparam int MODE_CLAMP  = 1;

    // Region codes.
    localparam logic [REGION_W-1:0] REGION_INSIDE = 2'd0;
    localparam logic [REGION_W-1:0] REGION_BELOW  = 2'd1;
    localparam logic [REGION_W-1:0] REGION_ABOVE  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PREP,
        S_DIV,
        S_MUL,
        S_SUM,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [SEG_W-1:0]  segment_count;
        logic [MODE_W-1:0] mode;
    } t_cfg;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] x;
        logic signed [DATA_WIDTH-1:0] y;
    } t_point;

    typedef struct packed {
        logic signed [ALU_W-1:0] a;
        logic signed [ALU_W-1:0] b;
        logic                    sub;
    } t_alu_req;

endpackage

// File: rtl/plm_regs.sv
module plm_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [plm_pkg::ADDR_W-1:0]    paddr,
    input  logic [plm_pkg::APB_DW-1:0]    pwdata,
    output logic [plm_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    output plm_pkg::t_cfg                 o_cfg,
    input  logic [plm_pkg::PT_IDX_W-1:0]  i_pt_idx,
    output plm_pkg::t_point               o_pt
);

    logic [plm_pkg::SEG_W-1:0]  r_segment_count;
    logic [plm_pkg::MODE_W-1:0] r_mode;
    logic [plm_pkg::APB_DW-1:0] r_pair [plm_pkg::NUM_PAIRS];
    logic [plm_pkg::REG_W-1:0]  w_reg;
    logic                       w_wr;
    logic [plm_pkg::APB_DW-1:0] w_pair;
    logic [31:0]                w_half;

    assign pready = 1'b1;
    assign w_reg  = paddr[plm_pkg::ADDR_W-1:3];
    assign w_wr   = psel && penable && pwrite && pready;

    // Register writes; addresses beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_segment_count <= plm_pkg::SEG_W'(1);
            r_mode          <= '0;
            for (int k = 0; k < plm_pkg::NUM_PAIRS; k++) begin
                r_pair[k] <= '0;
            end
        end else if (w_wr) begin
            case (w_reg)
                plm_pkg::REG_SEGMENT_COUNT: r_segment_count <= pwdata[plm_pkg::SEG_W-1:0];
                plm_pkg::REG_MODE:          r_mode          <= pwdata[plm_pkg::MODE_W-1:0];
                plm_pkg::REG_PAIR_0:        r_pair[0]       <= pwdata;
                plm_pkg::REG_PAIR_1:        r_pair[1]       <= pwdata;
                plm_pkg::REG_PAIR_2:        r_pair[2]       <= pwdata;
                plm_pkg::REG_PAIR_3:        r_pair[3]       <= pwdata;
                plm_pkg::REG_PAIR_4:        r_pair[4]       <= pwdata;
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        case (w_reg)
            plm_pkg::REG_SEGMENT_COUNT: prdata = plm_pkg::APB_DW'(r_segment_count);
            plm_pkg::REG_MODE:          prdata = plm_pkg::APB_DW'(r_mode);
            plm_pkg::REG_PAIR_0:        prdata = r_pair[0];
            plm_pkg::REG_PAIR_1:        prdata = r_pair[1];
            plm_pkg::REG_PAIR_2:        prdata = r_pair[2];
            plm_pkg::REG_PAIR_3:        prdata = r_pair[3];
            plm_pkg::REG_PAIR_4:        prdata = r_pair[4];
            default:                    prdata = '0;
        endcase
    end

    assign o_cfg.segment_count = r_segment_count;
    assign o_cfg.mode          = r_mode;

    // Point lookup for the sequencer: pair select, then half select.
    always_comb begin
        case (i_pt_idx[plm_pkg::PT_IDX_W-1:1])
            3'd0:    w_pair = r_pair[0];
            3'd1:    w_pair = r_pair[1];
            3'd2:    w_pair = r_pair[2];
            3'd3:    w_pair = r_pair[3];
            3'd4:    w_pair = r_pair[4];
            default: w_pair = '0;
        endcase
        w_half = i_pt_idx[0] ? w_pair[63:32] : w_pair[31:0];
    end

    assign o_pt.x = w_half[15:0];
    assign o_pt.y = w_half[31:16];

endmodule

// File: rtl/plm_alu.sv
module plm_alu (
    input  plm_pkg::t_alu_req                i_req,
    output logic signed [plm_pkg::ALU_W-1:0] o_sum
);

    // Shared adder: divider trial subtract, multiplier accumulate, final offset.
    assign o_sum = i_req.sub ? (i_req.a - i_req.b) : (i_req.a + i_req.b);

endmodule

// File: rtl/plm_seq.sv
`include "piecewise_linear_mapper_defines.svh"

module plm_seq (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [plm_pkg::DATA_WIDTH-1:0] i_x_in,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [plm_pkg::DATA_WIDTH-1:0] o_y_out,
    output logic [plm_pkg::SEG_W-1:0]            o_segment_used,
    output logic [plm_pkg::REGION_W-1:0]         o_region,
    output logic                                 o_config_error,
    input  plm_pkg::t_cfg                        i_cfg,
    output logic [plm_pkg::PT_IDX_W-1:0]         o_pt_idx,
    input  plm_pkg::t_point                      i_pt,
    output plm_pkg::t_alu_req                    o_alu,
    input  logic signed [plm_pkg::ALU_W-1:0]     i_alu_sum
);

    localparam int DW = plm_pkg::DATA_WIDTH;

    plm_pkg::t_state r_state;
    plm_pkg::t_state n_state;

    // Scan state.
    logic signed [DW-1:0]             r_x;
    logic [plm_pkg::PT_IDX_W-1:0]     r_i;
    logic [plm_pkg::SEG_W-1:0]        r_n;
    logic                             r_err;
    logic                             r_found;
    logic                             r_below;
    logic                             r_above;
    logic [plm_pkg::SEG_W-1:0]        r_seg;
    logic signed [DW-1:0]             r_px_prev;
    logic signed [DW-1:0]             r_py_prev;
    logic signed [DW-1:0]             r_sx0;
    logic signed [DW-1:0]             r_sy0;
    logic signed [DW-1:0]             r_sx1;
    logic signed [DW-1:0]             r_sy1;
    logic signed [DW-1:0]             r_ymin;
    logic signed [DW-1:0]             r_ymax;

    // Divide and multiply state.
    logic [DW-1:0]                    r_rem;
    logic [plm_pkg::QUO_W-1:0]        r_dvd;
    logic [DW-1:0]                    r_dx;
    logic [DW-1:0]                    r_dy_mag;
    logic                             r_neg_p;
    logic [plm_pkg::ACC_W-1:0]        r_acc;
    logic [plm_pkg::CNT_W-1:0]        r_cnt;

    // Finished result and output register.
    logic signed [DW-1:0]             r_res_y;
    logic [plm_pkg::SEG_W-1:0]        r_res_seg;
    logic [plm_pkg::REGION_W-1:0]     r_res_region;
    logic                             r_res_err;
    logic                             r_out_valid;
    logic signed [DW-1:0]             r_y_out;
    logic [plm_pkg::SEG_W-1:0]        r_seg_out;
    logic [plm_pkg::REGION_W-1:0]     r_region_out;
    logic                             r_err_out;

    logic                             w_accept;
    logic                             w_bad_count;
    logic                             w_extrap;
    logic                             w_hold;
    logic [plm_pkg::REGION_W-1:0]     w_region;
    logic                             w_in_iv;
    logic                             w_load;
    logic [DW:0]                      w_rem_sh;
    logic                             w_fits;
    logic signed [DW:0]               w_num;
    logic signed [DW:0]               w_dx;
    logic signed [DW:0]               w_dy;
    logic [DW:0]                      w_num_mag;
    logic [DW:0]                      w_dy_mag;
    logic signed [DW-1:0]             w_sat;
    logic signed [DW-1:0]             w_y;

    assign w_accept    = i_valid && o_ready;
    assign w_bad_count = (i_cfg.segment_count == '0) ||
                         (i_cfg.segment_count > plm_pkg::SEG_W'(plm_pkg::MAX_SEGMENTS));
    assign w_extrap    = i_cfg.mode[plm_pkg::MODE_EXTRAP];
    assign w_region    = r_below ? plm_pkg::REGION_BELOW :
                         r_above ? plm_pkg::REGION_ABOVE : plm_pkg::REGION_INSIDE;
    assign w_hold      = (w_region != plm_pkg::REGION_INSIDE) && !w_extrap;
    assign w_in_iv     = (r_x >= r_px_prev) && (r_x <= i_pt.x);
    assign w_load      = (r_state == plm_pkg::S_DONE) && (!r_out_valid || i_ready);

    // Segment differences formed once the scan has picked the segment.
    assign w_num     = {r_x[DW-1], r_x} - {r_sx0[DW-1], r_sx0};
    assign w_dx      = {r_sx1[DW-1], r_sx1} - {r_sx0[DW-1], r_sx0};
    assign w_dy      = {r_sy1[DW-1], r_sy1} - {r_sy0[DW-1], r_sy0};
    assign w_num_mag = w_num[DW] ? (DW+1)'(-w_num) : w_num;
    assign w_dy_mag  = w_dy[DW] ? (DW+1)'(-w_dy) : w_dy;

    // Restoring divide step: shift in the next dividend bit, trial subtract.
    assign w_rem_sh = {r_rem, r_dvd[plm_pkg::QUO_W-1]};
    assign w_fits   = !i_alu_sum[plm_pkg::ALU_W-1];

    // Final saturation and optional clamp of in-range results.
    always_comb begin
        if (i_alu_sum > plm_pkg::SAT_HI) begin
            w_sat = i_alu_sum[DW-1:0] ^ i_alu_sum[DW-1:0] ^ plm_pkg::SAT_HI[DW-1:0];
        end else if (i_alu_sum < plm_pkg::SAT_LO) begin
            w_sat = plm_pkg::SAT_LO[DW-1:0];
        end else begin
            w_sat = i_alu_sum[DW-1:0];
        end
        w_y = w_sat;
        if ((w_region == plm_pkg::REGION_INSIDE) && i_cfg.mode[plm_pkg::MODE_CLAMP]) begin
            if (w_sat < r_ymin) begin
                w_y = r_ymin;
            end
            if (w_sat > r_ymax) begin
                w_y = r_ymax;
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            plm_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = w_bad_count ? plm_pkg::S_DONE : plm_pkg::S_SCAN;
                end
            end
            plm_pkg::S_SCAN: begin
                if (r_i == plm_pkg::PT_IDX_W'(r_n)) begin
                    n_state = plm_pkg::S_PREP;
                end
            end
            plm_pkg::S_PREP: begin
                n_state = (r_err || w_hold) ? plm_pkg::S_DONE : plm_pkg::S_DIV;
            end
            plm_pkg::S_DIV: begin
                if (r_cnt == plm_pkg::CNT_W'(plm_pkg::QUO_W - 1)) begin
                    n_state = plm_pkg::S_MUL;
                end
            end
            plm_pkg::S_MUL: begin
                if (r_cnt == plm_pkg::CNT_W'(DW - 1)) begin
                    n_state = plm_pkg::S_SUM;
                end
            end
            plm_pkg::S_SUM: n_state = plm_pkg::S_DONE;
            plm_pkg::S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_state = plm_pkg::S_IDLE;
                end
            end
            default: n_state = plm_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshake, point lookup and adder operands.
    always_comb begin
        o_ready   = (r_state == plm_pkg::S_IDLE);
        o_pt_idx  = r_i;
        o_alu.a   = '0;
        o_alu.b   = '0;
        o_alu.sub = 1'b0;
        case (r_state)
            plm_pkg::S_DIV: begin
                o_alu.a   = plm_pkg::ALU_W'(w_rem_sh);
                o_alu.b   = plm_pkg::ALU_W'(r_dx);
                o_alu.sub = 1'b1;
            end
            plm_pkg::S_MUL: begin
                o_alu.a = plm_pkg::ALU_W'({r_acc, 1'b0});
                o_alu.b = r_dy_mag[DW-1] ? plm_pkg::ALU_W'(r_dvd) : '0;
            end
            plm_pkg::S_SUM: begin
                o_alu.a   = plm_pkg::ALU_W'(r_sy0);
                o_alu.b   = plm_pkg::ALU_W'(r_acc[plm_pkg::ACC_W-1:plm_pkg::FRAC_BITS]);
                o_alu.sub = r_neg_p;
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= plm_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_i         <= '0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                plm_pkg::S_IDLE: r_i <= '0;
                plm_pkg::S_SCAN: r_i <= r_i + plm_pkg::PT_IDX_W'(1);
                default: ;
            endcase
            if ((r_state == plm_pkg::S_PREP) || (n_state != r_state)) begin
                r_cnt <= '0;
            end else if ((r_state == plm_pkg::S_DIV) || (r_state == plm_pkg::S_MUL)) begin
                r_cnt <= r_cnt + plm_pkg::CNT_W'(1);
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            plm_pkg::S_IDLE: begin
                if (w_accept) begin
                    r_x          <= i_x_in;
                    r_n          <= i_cfg.segment_count;
                    r_err        <= w_bad_count;
                    r_found      <= 1'b0;
                    r_above      <= 1'b0;
                    r_res_y      <= '0;
                    r_res_seg    <= '0;
                    r_res_region <= plm_pkg::REGION_INSIDE;
                    r_res_err    <= 1'b1;
                end
            end
            plm_pkg::S_SCAN: begin
                // One curve point per cycle: order check, range, segment pick.
                r_px_prev <= i_pt.x;
                r_py_prev <= i_pt.y;
                if (r_i == '0) begin
                    r_below <= (r_x < i_pt.x);
                    r_ymin  <= i_pt.y;
                    r_ymax  <= i_pt.y;
                end else begin
                    if (r_px_prev >= i_pt.x) begin
                        r_err <= 1'b1;
                    end
                    if (i_pt.y < r_ymin) begin
                        r_ymin <= i_pt.y;
                    end
                    if (i_pt.y > r_ymax) begin
                        r_ymax <= i_pt.y;
                    end
                    if (!r_found) begin
                        r_sx0 <= r_px_prev;
                        r_sy0 <= r_py_prev;
                        r_sx1 <= i_pt.x;
                        r_sy1 <= i_pt.y;
                        r_seg <= plm_pkg::SEG_W'(r_i - plm_pkg::PT_IDX_W'(1));
                        if (w_in_iv || ((r_i == plm_pkg::PT_IDX_W'(1)) && r_below)) begin
                            r_found <= 1'b1;
                        end
                    end
                end
                if (r_i == plm_pkg::PT_IDX_W'(r_n)) begin
                    r_above <= (r_x > i_pt.x);
                end
            end
            plm_pkg::S_PREP: begin
                r_rem        <= '0;
                r_dvd        <= {w_num_mag[DW-1:0], {plm_pkg::FRAC_BITS{1'b0}}};
                r_dx         <= w_dx[DW-1:0];
                r_dy_mag     <= w_dy_mag[DW-1:0];
                r_neg_p      <= w_num[DW] ^ w_dy[DW];
                r_acc        <= '0;
                r_res_err    <= r_err;
                r_res_region <= r_err ? plm_pkg::REGION_INSIDE : w_region;
                r_res_seg    <= (r_err || w_hold) ? '0 : r_seg;
                r_res_y      <= r_err ? '0 : (r_below ? r_sy0 : r_sy1);
            end
            plm_pkg::S_DIV: begin
                r_rem <= w_fits ? i_alu_sum[DW-1:0] : w_rem_sh[DW-1:0];
                r_dvd <= {r_dvd[plm_pkg::QUO_W-2:0], w_fits};
            end
            plm_pkg::S_MUL: begin
                r_acc    <= i_alu_sum[plm_pkg::ACC_W-1:0];
                r_dy_mag <= {r_dy_mag[DW-2:0], 1'b0};
            end
            plm_pkg::S_SUM: begin
                r_res_y <= w_y;
            end
            plm_pkg::S_DONE: begin
                if (w_load) begin
                    r_y_out      <= r_res_y;
                    r_seg_out    <= r_res_seg;
                    r_region_out <= r_res_region;
                    r_err_out    <= r_res_err;
                end
            end
            default: ;
        endcase
    end

    assign o_valid        = r_out_valid;
    assign o_y_out        = r_y_out;
    assign o_segment_used = r_seg_out;
    assign o_region       = r_region_out;
    assign o_config_error = r_err_out;

    `PLM_ASSERT_NOW(a_err_payload, i_clk, i_rst_n, r_out_valid && r_err_out,
        (r_y_out == '0) && (r_seg_out == '0) && (r_region_out == plm_pkg::REGION_INSIDE),
        "error result carries a nonzero payload")
    `PLM_ASSERT_NOW(a_rem_below_dx, i_clk, i_rst_n, r_state == plm_pkg::S_DIV,
        r_rem < r_dx, "divider remainder not below divisor")
    `PLM_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept,
        (r_state == plm_pkg::S_SCAN) || (r_state == plm_pkg::S_DONE),
        "accepted sample did not start the sequencer")
    `PLM_ASSERT_NOW(a_seg_range, i_clk, i_rst_n, r_out_valid,
        r_seg_out < plm_pkg::SEG_W'(plm_pkg::MAX_SEGMENTS), "segment index out of range")

endmodule

// File: rtl/piecewise_linear_mapper.sv
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_ready    i_x_in
// output    out        o_valid / i_ready    o_y_out, o_segment_used, o_region, o_config_error
// config    in         psel / penable       paddr, pwdata, pwrite; prdata, pready
//
// After its transfer in, a result passes a scan of segment_count + 1 points, a setup state,
// 32 divide steps, 16 multiply steps, a sum state and a load, all on the one shared adder.
// A new sample is taken only once the result has been loaded into the output register.
// A zero or too large count goes straight to the load; unordered points or an end value
// without extrapolation skip from setup to the load. Reset is synchronous and active low.
// A stalled result sits in the output register; the next one then holds off the input.
module piecewise_linear_mapper (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [plm_pkg::DATA_WIDTH-1:0] i_x_in,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [plm_pkg::DATA_WIDTH-1:0] o_y_out,
    output logic [plm_pkg::SEG_W-1:0]            o_segment_used,
    output logic [plm_pkg::REGION_W-1:0]         o_region,
    output logic                                 o_config_error,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [plm_pkg::ADDR_W-1:0]           paddr,
    input  logic [plm_pkg::APB_DW-1:0]           pwdata,
    output logic [plm_pkg::APB_DW-1:0]           prdata,
    output logic                                 pready
);

    plm_pkg::t_cfg                        w_cfg;
    plm_pkg::t_point                      w_pt;
    logic [plm_pkg::PT_IDX_W-1:0]         w_pt_idx;
    plm_pkg::t_alu_req                    w_alu_req;
    logic signed [plm_pkg::ALU_W-1:0]     w_alu_sum;

    // Configuration registers and point lookup.
    plm_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cfg    (w_cfg),
        .i_pt_idx (w_pt_idx),
        .o_pt     (w_pt)
    );

    // Shared adder.
    plm_alu u_alu (
        .i_req (w_alu_req),
        .o_sum (w_alu_sum)
    );

    // Sequencer with scan, divide and multiply datapath.
    plm_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_x_in         (i_x_in),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_y_out        (o_y_out),
        .o_segment_used (o_segment_used),
        .o_region       (o_region),
        .o_config_error (o_config_error),
        .i_cfg          (w_cfg),
        .o_pt_idx       (w_pt_idx),
        .i_pt           (w_pt),
        .o_alu          (w_alu_req),
        .i_alu_sum      (w_alu_sum)
    );

endmodule
